// File: hdl/stl_pkg.sv
// Shared types and constants for the source text lexer.
// Holds the lexer mode and token kind codes, the token record and the character constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

	localparam int unsigned FIFO_DEPTH = 8;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [19:0] ROW_MAX  = 20'hFFFFF;
	localparam logic [15:0] COL_MAX  = 16'hFFFF;
	localparam int unsigned HASH_MUL = 31;

	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_VT     = 8'd11;
	localparam logic [7:0] CH_FF     = 8'd12;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

	typedef enum logic [2:0] {
		LM_IDLE       = 3'd0,
		LM_IDENT      = 3'd1,
		LM_NUMBER     = 3'd2,
		LM_STRING     = 3'd3,
		LM_CHAR_BODY  = 3'd4,
		LM_CHAR_CLOSE = 3'd5
	} lex_mode_t;

	typedef enum logic [4:0] {
		TK_UNDEF  = 5'd0,
		TK_EOF    = 5'd1,
		TK_IDENT  = 5'd2,
		TK_NUMBER = 5'd3,
		TK_STRING = 5'd4,
		TK_CHAR   = 5'd5,
		TK_PLUS   = 5'd6,
		TK_MINUS  = 5'd7,
		TK_STAR   = 5'd8,
		TK_SLASH  = 5'd9,
		TK_LPAREN = 5'd10,
		TK_RPAREN = 5'd11,
		TK_LBRACE = 5'd12,
		TK_RBRACE = 5'd13,
		TK_LBRACK = 5'd14,
		TK_RBRACK = 5'd15,
		TK_EQUAL  = 5'd16,
		TK_SEMI   = 5'd17
	} token_kind_t;

	typedef struct packed {
		token_kind_t kind;
		logic [19:0] srow;
		logic [15:0] scol;
		logic [15:0] ecol;
		logic [31:0] hash;
		logic [15:0] len;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic a_v;
		tok_t a;
		logic b_v;
		tok_t b;
	} tok_push_t;

	function automatic token_kind_t op_kind(input logic [7:0] b);
		token_kind_t k;
		case (b)
			CH_PLUS:   k = TK_PLUS;
			CH_MINUS:  k = TK_MINUS;
			CH_STAR:   k = TK_STAR;
			CH_SLASH:  k = TK_SLASH;
			CH_LPAREN: k = TK_LPAREN;
			CH_RPAREN: k = TK_RPAREN;
			CH_LBRACE: k = TK_LBRACE;
			CH_RBRACE: k = TK_RBRACE;
			CH_LBRACK: k = TK_LBRACK;
			CH_RBRACK: k = TK_RBRACK;
			CH_EQUAL:  k = TK_EQUAL;
			CH_SEMI:   k = TK_SEMI;
			default:   k = TK_UNDEF;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: hdl/stl_byte_if.sv
// Input channel of the lexer: one source byte or an end-of-input mark per transfer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface stl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_input;

	modport source (output valid, output text_byte, output end_of_input, input ready);
	modport sink (input valid, input text_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// File: hdl/stl_token_if.sv
// Output channel of the lexer: one token per transfer.
// Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface stl_token_if;
	import stl_pkg::*;

	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [19:0] start_row;
	logic [15:0] start_column;
	logic [19:0] end_row;
	logic [15:0] end_column;
	logic [31:0] name_hash;
	logic [15:0] name_length;
	logic        last_of_run;

	modport source (
		output valid, output token_kind, output start_row, output start_column,
		output end_row, output end_column, output name_hash, output name_length,
		output last_of_run, input ready
	);
	modport sink (
		input valid, input token_kind, input start_row, input start_column,
		input end_row, input end_column, input name_hash, input name_length,
		input last_of_run, output ready
	);
endinterface

`default_nettype wire

// File: hdl/stl_lex_core.sv
// Lexer core: input register, mode and position state, and the decode that forms
// up to two tokens per byte. Depends on stl_pkg and stl_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module stl_lex_core #(
	parameter int unsigned HASH_BITS = 32
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	stl_byte_if.sink                      text_in,
	input  wire logic [stl_pkg::CNT_W-1:0] fifo_count,
	output stl_pkg::tok_push_t            push
);
	import stl_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eof_s1;
	lex_mode_t            mode_q, mode_d;
	logic [19:0]          row_q, row_d, srow_q, srow_d;
	logic [15:0]          col_q, col_d, scol_q, scol_d;
	logic [HASH_BITS-1:0] hash_q, hash_d, hash_step;
	logic [15:0]          len_q, len_d;
	logic [31:0]          hash32;

	logic        is_letter, is_digit, is_nl, is_ws, is_dq, is_sq, is_us;
	logic        extend, do_fresh, fresh_starts, fresh_single;
	logic [15:0] col_p1, col_p2;
	logic [19:0] row_p1, eof_row;
	logic [CNT_W:0] room_need;

	assign room_need     = {1'b0, fifo_count} + (valid_s1 ? (CNT_W + 1)'(2) : '0);
	assign text_in.ready = room_need <= (CNT_W + 1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= text_in.valid & text_in.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid & text_in.ready) begin
			byte_s1 <= text_in.text_byte;
			eof_s1  <= text_in.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= LM_IDLE;
			row_q  <= 20'd1;
			col_q  <= '0;
			srow_q <= 20'd1;
			scol_q <= '0;
			hash_q <= '0;
			len_q  <= '0;
		end else begin
			mode_q <= mode_d;
			row_q  <= row_d;
			col_q  <= col_d;
			srow_q <= srow_d;
			scol_q <= scol_d;
			hash_q <= hash_d;
			len_q  <= len_d;
		end
	end

	generate
		if (HASH_BITS >= 32) begin : g_hash_wide
			assign hash32 = hash_q[31:0];
		end else begin : g_hash_narrow
			assign hash32 = {{(32 - HASH_BITS){1'b0}}, hash_q};
		end
	endgenerate

	assign hash_step = hash_q ^ ((hash_q * HASH_BITS'(HASH_MUL)) + HASH_BITS'(byte_s1));

	assign is_letter = (byte_s1 >= 8'h61 && byte_s1 <= 8'h7A) ||
		(byte_s1 >= 8'h41 && byte_s1 <= 8'h5A);
	assign is_digit  = byte_s1 >= 8'h30 && byte_s1 <= 8'h39;
	assign is_nl     = byte_s1 == CH_NL;
	assign is_ws     = byte_s1 == CH_TAB || byte_s1 == CH_VT || byte_s1 == CH_FF ||
		byte_s1 == CH_CR || byte_s1 == CH_SPACE;
	assign is_dq     = byte_s1 == CH_DQUOTE;
	assign is_sq     = byte_s1 == CH_SQUOTE;
	assign is_us     = byte_s1 == CH_USCORE;

	assign col_p1  = (col_q < COL_MAX) ? col_q + 16'd1 : COL_MAX;
	assign col_p2  = (col_q < COL_MAX - 16'd1) ? col_q + 16'd2 : COL_MAX;
	assign row_p1  = (row_q < ROW_MAX) ? row_q + 20'd1 : ROW_MAX;
	assign eof_row = (col_q != '0) ? row_p1 : row_q;

	always_comb begin
		case (mode_q)
			LM_IDENT:      extend = is_letter | is_digit | is_us;
			LM_NUMBER:     extend = is_digit;
			LM_STRING:     extend = !is_nl;
			LM_CHAR_BODY:  extend = !is_nl;
			LM_CHAR_CLOSE: extend = is_sq;
			default:       extend = 1'b0;
		endcase
	end

	assign do_fresh     = !eof_s1 && !extend;
	assign fresh_starts = do_fresh && !is_nl && !is_ws;
	assign fresh_single = fresh_starts && !is_letter && !is_digit && !is_dq && !is_sq;

	// Next state.
	always_comb begin
		mode_d = mode_q;
		row_d  = row_q;
		col_d  = col_q;
		srow_d = srow_q;
		scol_d = scol_q;
		hash_d = hash_q;
		len_d  = len_q;
		if (valid_s1) begin
			if (eof_s1) begin
				mode_d = LM_IDLE;
				row_d  = eof_row;
				col_d  = '0;
				srow_d = eof_row;
				scol_d = 16'd1;
			end else if (extend) begin
				col_d = col_p1;
				case (mode_q)
					LM_IDENT: begin
						hash_d = hash_step;
						len_d  = (len_q < COL_MAX) ? len_q + 16'd1 : COL_MAX;
					end
					LM_STRING:     mode_d = is_dq ? LM_IDLE : LM_STRING;
					LM_CHAR_BODY:  mode_d = LM_CHAR_CLOSE;
					LM_CHAR_CLOSE: mode_d = LM_IDLE;
					default:       mode_d = mode_q;
				endcase
			end else if (is_nl) begin
				mode_d = LM_IDLE;
				row_d  = row_p1;
				col_d  = '0;
			end else begin
				mode_d = LM_IDLE;
				col_d  = col_p1;
				if (!is_ws) begin
					srow_d = row_q;
					scol_d = col_p1;
				end
				if (is_letter) begin
					mode_d = LM_IDENT;
					hash_d = HASH_BITS'(byte_s1);
					len_d  = 16'd1;
				end else if (is_digit) begin
					mode_d = LM_NUMBER;
				end else if (is_dq) begin
					mode_d = LM_STRING;
				end else if (is_sq) begin
					mode_d = LM_CHAR_BODY;
				end
			end
		end
	end

	// Token outputs.
	always_comb begin
		push.a_v    = 1'b0;
		push.a.kind = TK_UNDEF;
		push.a.srow = srow_q;
		push.a.scol = scol_q;
		push.a.ecol = col_p1;
		push.a.hash = '0;
		push.a.len  = '0;
		push.b_v    = 1'b0;
		push.b.kind = op_kind(byte_s1);
		push.b.srow = row_q;
		push.b.scol = col_p1;
		push.b.ecol = col_p2;
		push.b.hash = '0;
		push.b.len  = '0;
		push.b.last = 1'b1;
		if (valid_s1) begin
			if ((eof_s1 || !extend) && mode_q != LM_IDLE) begin
				push.a_v = 1'b1;
				case (mode_q)
					LM_IDENT: begin
						push.a.kind = TK_IDENT;
						push.a.hash = hash32;
						push.a.len  = len_q;
					end
					LM_NUMBER: push.a.kind = TK_NUMBER;
					LM_STRING: push.a.ecol = col_q;
					default:   push.a.kind = TK_UNDEF;
				endcase
			end else if (!eof_s1 && extend &&
				((mode_q == LM_STRING && is_dq) || mode_q == LM_CHAR_CLOSE)) begin
				push.a_v    = 1'b1;
				push.a.kind = (mode_q == LM_STRING) ? TK_STRING : TK_CHAR;
				push.a.ecol = col_p2;
			end
			if (eof_s1) begin
				push.b_v    = 1'b1;
				push.b.kind = TK_EOF;
				push.b.srow = eof_row;
				push.b.scol = 16'd1;
				push.b.ecol = 16'd2;
			end else if (fresh_single) begin
				push.b_v = 1'b1;
			end
		end
		push.a.last = !push.b_v;
	end

endmodule

`default_nettype wire

// File: hdl/stl_token_fifo.sv
// Token queue between the lexer core and the output channel.
// Takes up to two tokens per cycle and presents one. Depends on stl_pkg and stl_token_if.
`timescale 1ns / 1ps
`default_nettype none

module stl_token_fifo (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  stl_pkg::tok_push_t             push,
	stl_token_if.source                    token_out,
	output logic [stl_pkg::CNT_W-1:0]      count
);
	import stl_pkg::*;

	tok_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       n_push;
	logic             pop;
	tok_t             first, head;

	assign n_push = {1'b0, push.a_v} + {1'b0, push.b_v};
	assign first  = push.a_v ? push.a : push.b;
	assign pop    = token_out.valid & token_out.ready;
	assign count  = count_q;

	always_ff @(posedge clk) begin
		if (push.a_v | push.b_v) begin
			mem_q[wr_q] <= first;
		end
		if (push.a_v & push.b_v) begin
			mem_q[wr_q + PTR_W'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(n_push);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

	assign head                   = mem_q[rd_q];
	assign token_out.valid        = count_q != '0;
	assign token_out.token_kind   = head.kind;
	assign token_out.start_row    = head.srow;
	assign token_out.start_column = head.scol;
	assign token_out.end_row      = head.srow;
	assign token_out.end_column   = head.ecol;
	assign token_out.name_hash    = head.hash;
	assign token_out.name_length  = head.len;
	assign token_out.last_of_run  = head.last;

endmodule

`default_nettype wire

// File: hdl/source_text_lexer_top.sv
// Top level of the source text lexer: byte channel in, token channel out.
// Depends on stl_pkg, stl_byte_if, stl_token_if, stl_lex_core and stl_token_fifo.
//
// Usage: text_in carries one source byte per transfer, or an end-of-input mark that
// flushes any pending token and produces an end-of-file token. token_out carries one
// token per transfer with its kind, start and end positions, identifier hash and length;
// last_of_run marks the final token caused by one input transfer.
// Path: an accepted byte is held in the input register, and the tokens it completes are
// then written into an eight-entry token queue, from whose head they are taken.
// Throughput: one byte per cycle while the queue has room. A byte gives at most two
// tokens; the output side drains one token per cycle, so runs of bytes that each complete
// two tokens slow the input to the output rate. The input is ready while the queue has
// room for two tokens beyond those the byte in the input register may still produce.
// Reset: the queue empties, the lexer returns to idle at row 1, column 0.
// When the receiver stalls, tokens wait in the queue and the input stops once it lacks room.
`timescale 1ns / 1ps
`default_nettype none

module source_text_lexer_top #(
	parameter int unsigned HASH_BITS = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stl_byte_if.sink    text_in,
	stl_token_if.source token_out
);
	import stl_pkg::*;

	tok_push_t        push;
	logic [CNT_W-1:0] fifo_count;

	stl_lex_core #(
		.HASH_BITS(HASH_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_in    (text_in),
		.fifo_count (fifo_count),
		.push       (push)
	);

	stl_token_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.token_out (token_out),
		.count     (fifo_count)
	);

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= CNT_W'(FIFO_DEPTH))
		else $error("token queue count above its depth");

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		(text_in.valid && text_in.ready) |-> fifo_count <= CNT_W'(FIFO_DEPTH - 2))
		else $error("byte accepted without room for its tokens");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_out.valid && token_out.token_kind == TK_EOF) |->
		(token_out.last_of_run && token_out.end_column == 16'd2))
		else $error("end-of-file token malformed");

	a_col_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		token_out.valid |-> token_out.start_column != '0)
		else $error("token starts at column zero");

endmodule

`default_nettype wire

// File: test/source_text_lexer_top_test.sv
// Testbench for source_text_lexer_top: streams source bytes and end-of-input marks,
// predicts every token in a local lexer model and checks each token transfer field by field.
// Depends on stl_pkg, stl_byte_if, stl_token_if and the lexer RTL.
`timescale 1ns / 1ps

module source_text_lexer_top_test;
	import stl_pkg::*;

	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DIRECTED_COUNT = 28;
	localparam logic [11:0][7:0] OP_BYTES = {CH_SEMI, CH_EQUAL, CH_RBRACK, CH_LBRACK,
		CH_RBRACE, CH_LBRACE, CH_RPAREN, CH_LPAREN, CH_SLASH, CH_STAR, CH_MINUS, CH_PLUS};
	localparam logic [4:0][7:0] BLANK_BYTES = {CH_SPACE, CH_CR, CH_FF, CH_VT, CH_TAB};

	typedef struct packed {
		token_kind_t kind;
		logic [19:0] srow;
		logic [15:0] scol;
		logic [19:0] erow;
		logic [15:0] ecol;
		logic [31:0] hash;
		logic [15:0] len;
		logic        last;
	} lex_token_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        eoi;
		logic        typed;
		token_kind_t kind;
		logic [15:0] scol;
	} stim_row_t;

	logic clk;
	logic arst_n;

	stl_byte_if  text_in();
	stl_token_if token_out();

	source_text_lexer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.token_out (token_out)
	);

	lex_mode_t   p_mode = LM_IDLE;
	logic [19:0] p_row = 20'd1;
	logic [15:0] p_col = 16'd0;
	logic [19:0] p_tok_row = 20'd1;
	logic [15:0] p_tok_col = 16'd0;
	logic [31:0] p_hash = 32'd0;
	logic [15:0] p_len = 16'd0;

	lex_token_t  expected_tokens[$];
	stim_row_t   directed_rows [DIRECTED_COUNT];
	logic        typed_pending;
	lex_token_t  typed_token;
	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned src_idle_pct = 0;
	int unsigned sink_idle_pct = 0;
	int unsigned hold_left = 0;
	logic        hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] col_inc(input logic [15:0] c);
		return (c == COL_MAX) ? c : c + 16'd1;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic void push_token(input token_kind_t kind, input logic [15:0] ecol,
			input logic [31:0] hash, input logic [15:0] len);
		lex_token_t t;
		t = '{kind, p_tok_row, p_tok_col, p_tok_row, ecol, hash, len, 1'b0};
		expected_tokens.insert(expected_tokens.size(), t);
	endfunction

	function automatic void finish_pending();
		case (p_mode)
			LM_IDENT: push_token(TK_IDENT, col_inc(p_col), p_hash, p_len);
			LM_NUMBER: push_token(TK_NUMBER, col_inc(p_col), 32'd0, 16'd0);
			LM_STRING: push_token(TK_UNDEF, p_col, 32'd0, 16'd0);
			LM_CHAR_BODY, LM_CHAR_CLOSE: push_token(TK_UNDEF, col_inc(p_col), 32'd0, 16'd0);
			default: ;
		endcase
		p_mode = LM_IDLE;
	endfunction

	function automatic void start_lexeme(input logic [7:0] b);
		token_kind_t kind;
		if (b == CH_NL) begin
			if (p_row != ROW_MAX)
				p_row = p_row + 20'd1;
			p_col = 16'd0;
			return;
		end
		p_col = col_inc(p_col);
		if (b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR || b == CH_SPACE)
			return;
		p_tok_row = p_row;
		p_tok_col = p_col;
		if (is_letter(b)) begin
			p_mode = LM_IDENT;
			p_hash = {24'd0, b};
			p_len = 16'd1;
		end else if (is_digit(b)) begin
			p_mode = LM_NUMBER;
		end else if (b == CH_DQUOTE) begin
			p_mode = LM_STRING;
		end else if (b == CH_SQUOTE) begin
			p_mode = LM_CHAR_BODY;
		end else begin
			kind = TK_UNDEF;
			for (int i = 0; i < 12; i++)
				if (b == OP_BYTES[i])
					kind = token_kind_t'(int'(TK_PLUS) + i);
			push_token(kind, col_inc(p_col), 32'd0, 16'd0);
		end
	endfunction

	function automatic void predict_transfer(input logic [7:0] b, input logic eoi);
		int unsigned first;
		logic fresh;
		lex_token_t t;
		first = expected_tokens.size();
		fresh = 1'b1;
		if (eoi) begin
			finish_pending();
			if (p_col != 16'd0 && p_row != ROW_MAX)
				p_row = p_row + 20'd1;
			p_col = 16'd0;
			p_tok_row = p_row;
			p_tok_col = 16'd1;
			push_token(TK_EOF, 16'd2, 32'd0, 16'd0);
		end else begin
			case (p_mode)
				LM_IDENT: begin
					if (is_letter(b) || is_digit(b) || b == CH_USCORE) begin
						p_col = col_inc(p_col);
						p_hash = p_hash ^ (p_hash * 32'd31 + {24'd0, b});
						if (p_len != COL_MAX)
							p_len = p_len + 16'd1;
						fresh = 1'b0;
					end else
						finish_pending();
				end
				LM_NUMBER: begin
					if (is_digit(b)) begin
						p_col = col_inc(p_col);
						fresh = 1'b0;
					end else
						finish_pending();
				end
				LM_STRING: begin
					if (b == CH_NL)
						finish_pending();
					else begin
						p_col = col_inc(p_col);
						if (b == CH_DQUOTE) begin
							push_token(TK_STRING, col_inc(p_col), 32'd0, 16'd0);
							p_mode = LM_IDLE;
						end
						fresh = 1'b0;
					end
				end
				LM_CHAR_BODY: begin
					if (b == CH_NL)
						finish_pending();
					else begin
						p_col = col_inc(p_col);
						p_mode = LM_CHAR_CLOSE;
						fresh = 1'b0;
					end
				end
				LM_CHAR_CLOSE: begin
					if (b == CH_SQUOTE) begin
						p_col = col_inc(p_col);
						push_token(TK_CHAR, col_inc(p_col), 32'd0, 16'd0);
						p_mode = LM_IDLE;
						fresh = 1'b0;
					end else
						finish_pending();
				end
				default: p_mode = LM_IDLE;
			endcase
			if (fresh)
				start_lexeme(b);
		end
		if (expected_tokens.size() > first) begin
			t = expected_tokens[expected_tokens.size() - 1];
			t.last = 1'b1;
			expected_tokens[expected_tokens.size() - 1] = t;
		end
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
			error_count++;
		end
	endfunction

	function automatic void check_token(input lex_token_t got);
		lex_token_t want;
		if (expected_tokens.size() == 0) begin
			$display("%0t: token expected none, actual kind %0d row %0d column %0d",
				$time, got.kind, got.srow, got.scol);
			error_count++;
			return;
		end
		want = expected_tokens.pop_front();
		check_field("token_kind", want.kind, got.kind);
		check_field("start_row", want.srow, got.srow);
		check_field("start_column", want.scol, got.scol);
		check_field("end_row", want.erow, got.erow);
		check_field("end_column", want.ecol, got.ecol);
		check_field("name_hash", want.hash, got.hash);
		check_field("name_length", want.len, got.len);
		check_field("last_of_run", want.last, got.last);
	endfunction

	always @(posedge clk) begin : monitor
		lex_token_t got;
		if (arst_n && text_in.valid && text_in.ready) begin
			predict_transfer(text_in.text_byte, text_in.end_of_input);
			if (typed_pending)
				expected_tokens[expected_tokens.size() - 1] = typed_token;
		end
		if (arst_n && token_out.valid && token_out.ready) begin
			got = '{token_kind_t'(token_out.token_kind), token_out.start_row,
				token_out.start_column, token_out.end_row, token_out.end_column,
				token_out.name_hash, token_out.name_length, token_out.last_of_run};
			check_token(got);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (text_in.valid && text_in.ready) || (token_out.valid && token_out.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		token_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				token_out.ready <= 1'b0;
			end else
				token_out.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_transfer(input logic [7:0] b, input logic eoi, input logic typed,
			input lex_token_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			text_in.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		text_in.valid <= 1'b1;
		text_in.text_byte <= b;
		text_in.end_of_input <= eoi;
		typed_pending <= typed;
		typed_token <= want;
		do @(posedge clk); while (!text_in.ready);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_transfer(b, 1'b0, 1'b0, '0);
	endtask

	task automatic send_end();
		send_transfer(8'($urandom_range(255)), 1'b1, 1'b0, '0);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		text_in.valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_letter();
		int unsigned r;
		r = $urandom_range(51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_name_char();
		int unsigned r;
		r = $urandom_range(63);
		if (r < 52)
			return rand_letter();
		else if (r < 62)
			return 8'("0" + r - 52);
		return CH_USCORE;
	endfunction

	function automatic logic [7:0] any_but_newline();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		return (c == CH_NL) ? CH_SPACE : c;
	endfunction

	task automatic end_line_or_input();
		if ($urandom_range(1))
			send_byte(CH_NL);
		else
			send_end();
	endtask

	task automatic send_random_lexeme();
		int unsigned pick;
		int unsigned count;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 25) begin
			send_byte(rand_letter());
			count = $urandom_range(10);
			repeat (count) send_byte(rand_name_char());
		end else if (pick < 40) begin
			count = $urandom_range(6, 1);
			repeat (count) send_byte(8'("0" + $urandom_range(9)));
		end else if (pick < 48 || (pick >= 93 && pick < 96)) begin
			send_byte(CH_DQUOTE);
			count = $urandom_range(8);
			repeat (count) begin
				c = any_but_newline();
				send_byte((c == CH_DQUOTE) ? CH_SPACE : c);
			end
			if (pick < 48)
				send_byte(CH_DQUOTE);
			else
				end_line_or_input();
		end else if (pick < 54) begin
			send_byte(CH_SQUOTE);
			send_byte(any_but_newline());
			send_byte(CH_SQUOTE);
		end else if (pick < 70) begin
			send_byte(OP_BYTES[$urandom_range(11)]);
		end else if (pick < 82) begin
			send_byte(BLANK_BYTES[$urandom_range(4)]);
		end else if (pick < 88) begin
			send_byte(CH_NL);
		end else if (pick < 93) begin
			send_byte(8'($urandom_range(255)));
		end else if (pick < 99) begin
			send_byte(CH_SQUOTE);
			if ($urandom_range(1)) begin
				send_byte(any_but_newline());
				c = 8'($urandom_range(255));
				send_byte((c == CH_SQUOTE) ? CH_SPACE : c);
			end else
				end_line_or_input();
		end else
			send_end();
	endtask

	initial begin
		stim_row_t row;
		lex_token_t want;
		text_in.valid = 1'b0;
		text_in.text_byte = 8'd0;
		text_in.end_of_input = 1'b0;
		typed_pending = 1'b0;
		typed_token = '0;
		arst_n = 1'b0;
		directed_rows = '{
			'{CH_PLUS,   1'b0, 1'b1, TK_PLUS,   16'd1},
			'{CH_MINUS,  1'b0, 1'b1, TK_MINUS,  16'd2},
			'{CH_STAR,   1'b0, 1'b1, TK_STAR,   16'd3},
			'{CH_SLASH,  1'b0, 1'b1, TK_SLASH,  16'd4},
			'{CH_LPAREN, 1'b0, 1'b1, TK_LPAREN, 16'd5},
			'{CH_RPAREN, 1'b0, 1'b1, TK_RPAREN, 16'd6},
			'{CH_LBRACE, 1'b0, 1'b1, TK_LBRACE, 16'd7},
			'{CH_RBRACE, 1'b0, 1'b1, TK_RBRACE, 16'd8},
			'{CH_LBRACK, 1'b0, 1'b1, TK_LBRACK, 16'd9},
			'{CH_RBRACK, 1'b0, 1'b1, TK_RBRACK, 16'd10},
			'{CH_EQUAL,  1'b0, 1'b1, TK_EQUAL,  16'd11},
			'{CH_SEMI,   1'b0, 1'b1, TK_SEMI,   16'd12},
			'{8'h00,     1'b0, 1'b1, TK_UNDEF,  16'd13},
			'{8'hFF,     1'b0, 1'b1, TK_UNDEF,  16'd14},
			'{"z",       1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{"9",       1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{CH_USCORE, 1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{CH_SQUOTE, 1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{"q",       1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{CH_SQUOTE, 1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{CH_SQUOTE, 1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{CH_NL,     1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{CH_DQUOTE, 1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{"x",       1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{CH_NL,     1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{"7",       1'b0, 1'b0, TK_UNDEF,  16'd0},
			'{8'h00,     1'b1, 1'b0, TK_UNDEF,  16'd0},
			'{8'hA5,     1'b1, 1'b0, TK_UNDEF,  16'd0}
		};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idle_pct = 11;
		sink_idle_pct = 63;
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			row = directed_rows[i];
			want = '{row.kind, 20'd1, row.scol, 20'd1, row.scol + 16'd1, 32'd0, 16'd0, 1'b1};
			send_transfer(row.b, row.eoi, row.typed, want);
		end
		while (items_sent < 300)
			send_random_lexeme();
		hold_request = 1'b1;
		while (items_sent < 600)
			send_random_lexeme();

		src_idle_pct = 63;
		sink_idle_pct = 11;
		while (items_sent < 800)
			send_random_lexeme();
		wait_for_drain();
		while (items_sent < 1100)
			send_random_lexeme();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		while (items_sent < 1500)
			send_random_lexeme();

		send_end();
		send_end();

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
hdl/stl_pkg.sv
hdl/stl_byte_if.sv
hdl/stl_token_if.sv
hdl/stl_lex_core.sv
hdl/stl_token_fifo.sv
hdl/source_text_lexer_top.sv
test/source_text_lexer_top_test.sv
